/* rtl/simple_8bit_machine_step_top_defines.svh */
// Assertion macros shared by the checker of the simple 8-bit machine.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef SIMPLE_8BIT_MACHINE_STEP_TOP_DEFINES_SVH
`define SIMPLE_8BIT_MACHINE_STEP_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMS_ASSERT_NOW(name, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMS_ASSERT_NEXT(name, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

/* rtl/s8ms_pkg.sv */
// Package of the simple 8-bit machine: sequencer states, opcodes, command codes.
// No dependencies; imported by the top level and the checker.
package s8ms_pkg;

	typedef logic [7:0] byte_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_EXEC
	} seq_state_t;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	localparam logic [3:0] OP_LOAD_MEM = 4'h1;
	localparam logic [3:0] OP_LOAD_IMM = 4'h2;
	localparam logic [3:0] OP_STORE    = 4'h3;
	localparam logic [3:0] OP_MOVE     = 4'h4;
	localparam logic [3:0] OP_ADD      = 4'h5;
	localparam logic [3:0] OP_JUMP     = 4'hB;
	localparam logic [3:0] OP_HALT     = 4'hC;

	localparam int REG_COUNT = 16;

endpackage

/* rtl/s8ms_req_if.sv */
// Request channel of the simple 8-bit machine: load or step commands.
// Stand-alone interface, no dependencies.
interface s8ms_req_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] address;
	logic [7:0] data;

	modport source (output valid, command, address, data, input ready);
	modport sink   (input valid, command, address, data, output ready);
endinterface

/* rtl/s8ms_res_if.sv */
// Result channel of the simple 8-bit machine: one word per command.
// Stand-alone interface, no dependencies.
interface s8ms_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] executed_pc;
	logic [3:0] opcode;
	logic       jumped;
	logic       halted;
	logic       unknown_opcode;

	modport source (output valid, executed_pc, opcode, jumped, halted, unknown_opcode,
		input ready);
	modport sink   (input valid, executed_pc, opcode, jumped, halted, unknown_opcode,
		output ready);
endinterface

/* rtl/simple_8bit_machine_step_top.sv */
// Simple 8-bit teaching machine; uses s8ms_pkg, s8ms_req_if and s8ms_res_if.
// A load word passes through the input buffer and the output register; a step word also passes
// through the fetch, operand read and execute states, which use the main memory ports. The input
// buffer's ready is registered, so no new word is taken while the buffer still holds one.
// Reset clears the program counter and stop flag; memory and registers read as zero via valid bits.
module simple_8bit_machine_step_top
	import s8ms_pkg::*;
#(
	parameter int MEM_DEPTH = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	s8ms_req_if.sink       req,
	s8ms_res_if.source     res
);

	localparam int         MEM_AW  = $clog2(MEM_DEPTH);
	localparam logic [8:0] DEPTH_W = 9'(MEM_DEPTH);

	// An address is only backed by storage below the configured depth.
	function automatic logic in_range(input byte_t a);
		return {1'b0, a} < DEPTH_W;
	endfunction

	// ------------------------------------------------------------------
	// Input buffer. One word is held here so that a new command can be
	// taken while the sequencer is still busy with the previous one.
	// ------------------------------------------------------------------
	logic  ibuf_vld_q;
	logic  ibuf_cmd_q;
	byte_t ibuf_addr_q;
	byte_t ibuf_data_q;
	logic  ibuf_pop;

	assign req.ready = !ibuf_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ibuf_vld_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			ibuf_vld_q <= 1'b1;
		end else if (ibuf_pop) begin
			ibuf_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			ibuf_cmd_q  <= req.command;
			ibuf_addr_q <= req.address;
			ibuf_data_q <= req.data;
		end
	end

	// ------------------------------------------------------------------
	// Architectural control state.
	// ------------------------------------------------------------------
	seq_state_t state_q, state_d;
	logic [8:0] pc_q, pc_d;
	logic       stopped_q, stopped_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pc_q      <= '0;
			stopped_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			pc_q      <= pc_d;
			stopped_q <= stopped_d;
		end
	end

	// ------------------------------------------------------------------
	// Main memory: one write port, two read ports with registered data.
	// Port A fetches the opcode byte and later the operand byte at XY;
	// port B fetches the second instruction byte. A per-byte valid bit
	// stands in for the all-zero reset contents.
	// ------------------------------------------------------------------
	byte_t                mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] mem_vld_q;

	logic  mem_we;
	byte_t mem_wa, mem_wd;
	logic  mem_ra_en, mem_rb_en;
	byte_t mem_ra_addr, mem_rb_addr;
	byte_t mem_ra_q, mem_rb_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa[MEM_AW-1:0]] <= mem_wd;
		end
		if (mem_ra_en) begin
			mem_ra_q <= (in_range(mem_ra_addr) && mem_vld_q[mem_ra_addr[MEM_AW-1:0]]) ?
				mem[mem_ra_addr[MEM_AW-1:0]] : '0;
		end
		if (mem_rb_en) begin
			mem_rb_q <= (in_range(mem_rb_addr) && mem_vld_q[mem_rb_addr[MEM_AW-1:0]]) ?
				mem[mem_rb_addr[MEM_AW-1:0]] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_vld_q <= '0;
		end else if (mem_we) begin
			mem_vld_q[mem_wa[MEM_AW-1:0]] <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Register file: sixteen bytes, two registered read ports, one write
	// port, with valid bits for the zero reset value.
	// ------------------------------------------------------------------
	byte_t                rf [REG_COUNT];
	logic [REG_COUNT-1:0] rf_vld_q;

	logic       rf_rd_en;
	logic [3:0] rf_ra_addr, rf_rb_addr;
	byte_t      rf_ra_q, rf_rb_q;
	logic       rf_we;
	logic [3:0] rf_wa;
	byte_t      rf_wd;

	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf[rf_wa] <= rf_wd;
		end
		if (rf_rd_en) begin
			rf_ra_q <= rf_vld_q[rf_ra_addr] ? rf[rf_ra_addr] : '0;
			rf_rb_q <= rf_vld_q[rf_rb_addr] ? rf[rf_rb_addr] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (rf_we) begin
			rf_vld_q[rf_wa] <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Decoded instruction, captured when the fetch data arrive so that
	// port A can be reused for the operand read.
	// ------------------------------------------------------------------
	logic [3:0] op_s2;
	logic [3:0] r_s2;
	byte_t      xy_s2;
	logic       dec_load;

	logic [3:0] dec_op, dec_r, dec_s, dec_t;

	assign dec_op = mem_ra_q[7:4];
	assign dec_r  = mem_ra_q[3:0];
	assign dec_s  = mem_rb_q[7:4];
	assign dec_t  = mem_rb_q[3:0];

	always_ff @(posedge clk) begin
		if (dec_load) begin
			op_s2 <= dec_op;
			r_s2  <= dec_r;
			xy_s2 <= mem_rb_q;
		end
	end

	// ------------------------------------------------------------------
	// Output register. It parts the sequencer from the consumer, so a
	// finished result may wait while the next command is already taken.
	// ------------------------------------------------------------------
	logic       res_vld_q;
	byte_t      res_pc_q;
	logic [3:0] res_op_q;
	logic       res_jmp_q, res_halt_q, res_unk_q;

	logic       res_load;
	byte_t      res_pc_d;
	logic [3:0] res_op_d;
	logic       res_jmp_d, res_halt_d, res_unk_d;
	logic       out_free;

	assign out_free = !res_vld_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (res_load) begin
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_pc_q   <= res_pc_d;
			res_op_q   <= res_op_d;
			res_jmp_q  <= res_jmp_d;
			res_halt_q <= res_halt_d;
			res_unk_q  <= res_unk_d;
		end
	end

	assign res.valid          = res_vld_q;
	assign res.executed_pc    = res_pc_q;
	assign res.opcode         = res_op_q;
	assign res.jumped         = res_jmp_q;
	assign res.halted         = res_halt_q;
	assign res.unknown_opcode = res_unk_q;

	// ------------------------------------------------------------------
	// Sequencer. A load word writes memory straight from the idle state.
	// A step fetches both instruction bytes in idle, reads its register
	// operands and the byte at XY in decode, and writes back in execute.
	// Each step finishes its writes before the next fetch is issued, so
	// no forwarding between steps is needed.
	// ------------------------------------------------------------------
	logic [8:0] pc_next1;
	logic       pc_fits;

	assign pc_next1 = pc_q + 9'd1;
	assign pc_fits  = pc_next1 < DEPTH_W;

	always_comb begin
		state_d     = state_q;
		pc_d        = pc_q;
		stopped_d   = stopped_q;
		ibuf_pop    = 1'b0;
		dec_load    = 1'b0;
		mem_we      = 1'b0;
		mem_wa      = ibuf_addr_q;
		mem_wd      = ibuf_data_q;
		mem_ra_en   = 1'b0;
		mem_ra_addr = pc_q[7:0];
		mem_rb_en   = 1'b0;
		mem_rb_addr = pc_next1[7:0];
		rf_rd_en    = 1'b0;
		rf_ra_addr  = dec_r;
		rf_rb_addr  = '0;
		rf_we       = 1'b0;
		rf_wa       = r_s2;
		rf_wd       = xy_s2;
		res_load    = 1'b0;
		res_pc_d    = '0;
		res_op_d    = '0;
		res_jmp_d   = 1'b0;
		res_halt_d  = 1'b0;
		res_unk_d   = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (ibuf_vld_q) begin
					if (ibuf_cmd_q == CMD_LOAD) begin
						// Program byte: written even when stopped, out of range dropped.
						if (out_free) begin
							mem_we     = in_range(ibuf_addr_q);
							res_load   = 1'b1;
							res_halt_d = stopped_q;
							ibuf_pop   = 1'b1;
						end
					end else if (stopped_q) begin
						if (out_free) begin
							res_load   = 1'b1;
							res_halt_d = 1'b1;
							ibuf_pop   = 1'b1;
						end
					end else if (!pc_fits) begin
						// The instruction would run past the end of memory.
						if (out_free) begin
							stopped_d  = 1'b1;
							res_load   = 1'b1;
							res_pc_d   = pc_q[7:0];
							res_halt_d = 1'b1;
							ibuf_pop   = 1'b1;
						end
					end else begin
						mem_ra_en = 1'b1;
						mem_rb_en = 1'b1;
						ibuf_pop  = 1'b1;
						state_d   = ST_DECODE;
					end
				end
			end

			ST_DECODE: begin
				dec_load    = 1'b1;
				mem_ra_en   = 1'b1;
				mem_ra_addr = mem_rb_q;
				rf_rd_en    = 1'b1;
				// Move and add read S on port A; store and jump read R.
				rf_ra_addr  = (dec_op == OP_MOVE || dec_op == OP_ADD) ? dec_s : dec_r;
				// Add reads T on port B; jump compares against register zero.
				rf_rb_addr  = (dec_op == OP_ADD) ? dec_t : '0;
				state_d     = ST_EXEC;
			end

			ST_EXEC: begin
				if (out_free) begin
					res_load = 1'b1;
					res_pc_d = pc_q[7:0];
					res_op_d = op_s2;
					state_d  = ST_IDLE;
					case (op_s2)
						OP_LOAD_MEM: begin
							rf_we = 1'b1;
							rf_wd = mem_ra_q;
							pc_d  = pc_q + 9'd2;
						end
						OP_LOAD_IMM: begin
							rf_we = 1'b1;
							pc_d  = pc_q + 9'd2;
						end
						OP_STORE: begin
							mem_we = in_range(xy_s2);
							mem_wa = xy_s2;
							mem_wd = rf_ra_q;
							pc_d   = pc_q + 9'd2;
						end
						OP_MOVE: begin
							rf_we = 1'b1;
							rf_wa = xy_s2[3:0];
							rf_wd = rf_ra_q;
							pc_d  = pc_q + 9'd2;
						end
						OP_ADD: begin
							rf_we = 1'b1;
							rf_wd = rf_ra_q + rf_rb_q;
							pc_d  = pc_q + 9'd2;
						end
						OP_JUMP: begin
							if (rf_ra_q == rf_rb_q) begin
								pc_d      = {1'b0, xy_s2};
								res_jmp_d = 1'b1;
							end else begin
								pc_d = pc_q + 9'd2;
							end
						end
						OP_HALT: begin
							stopped_d = 1'b1;
						end
						default: begin
							stopped_d = 1'b1;
							res_unk_d = 1'b1;
						end
					endcase
					res_halt_d = stopped_d;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/s8ms_check.sv */
// Port-level checker for the simple 8-bit machine, bound to the top level.
// Uses s8ms_pkg and the assertion macros of simple_8bit_machine_step_top_defines.svh.
`include "simple_8bit_machine_step_top_defines.svh"

module s8ms_check
	import s8ms_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] res_executed_pc,
	input logic [3:0] res_opcode,
	input logic       res_jumped,
	input logic       res_halted,
	input logic       res_unknown_opcode
);

	logic [2:0] pend_q;
	logic       halt_seen_q;
	logic       req_acc, res_acc;

	assign req_acc = req_valid && req_ready;
	assign res_acc = res_valid && res_ready;

	// Words taken but not yet answered, and whether a stop has been reported.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			halt_seen_q <= 1'b0;
		end else begin
			pend_q <= pend_q + {2'b00, req_acc} - {2'b00, res_acc};
			if (res_acc && res_halted) begin
				halt_seen_q <= 1'b1;
			end
		end
	end

	`SMS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_executed_pc) && $stable(res_opcode) && $stable(res_halted), "result word changed while stalled")
	`SMS_ASSERT_NOW(a_no_orphan, res_valid, pend_q != 3'd0, "result word without a pending command")
	`SMS_ASSERT_NOW(a_stop_sticky, res_valid && halt_seen_q, res_halted, "machine left the stopped state")
	`SMS_ASSERT_NOW(a_jump_flags, res_valid && res_jumped, res_opcode == OP_JUMP && !res_halted && !res_unknown_opcode, "jump flag on a non-jump word")
	`SMS_ASSERT_NOW(a_unknown_halts, res_valid && res_unknown_opcode, res_halted, "undefined opcode did not stop the machine")

endmodule

bind simple_8bit_machine_step_top s8ms_check u_s8ms_check (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.res_executed_pc    (res.executed_pc),
	.res_opcode         (res.opcode),
	.res_jumped         (res.jumped),
	.res_halted         (res.halted),
	.res_unknown_opcode (res.unknown_opcode)
);
